// ----- rtl/core/lmt_pkg.sv -----
// Shared types, constants and a helper function for the LCD mode timing block.
package lmt_pkg;

    localparam logic [9:0] DOTS_PER_LINE   = 10'd456;
    localparam logic [9:0] MODE3_START     = 10'd80;
    localparam logic [9:0] MODE0_START     = 10'd252;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;
    localparam logic [7:0] VBLANK_LINE     = 8'd144;
    localparam logic [6:0] MAX_ADVANCE     = 7'd80;
    localparam int         CTRL_ON_BIT     = 7;
    localparam logic [7:0] STATUS_FIXED    = 8'h80;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_CONTROL = 2'd0,
        REG_STATUS  = 2'd1,
        REG_LINE    = 2'd2,
        REG_COMPARE = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] dot_count;
        logic [1:0] register_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render_start;
        logic       frame_end;
        logic [7:0] current_line;
        logic [1:0] current_mode;
    } result_t;

    typedef struct packed {
        logic [7:0] control;
        logic [3:0] stat_en;
        logic [7:0] line_compare;
        logic [7:0] line;
        logic [8:0] dot;
        mode_t      mode;
        logic       level;
    } timing_state_t;

    // Level of the status interrupt line for a given state, ignoring the display enable.
    function automatic logic stat_level(timing_state_t s);
        logic lvl;
        lvl = ((s.line == s.line_compare) && s.stat_en[3])
            || ((s.mode == MODE_HBLANK) && s.stat_en[0])
            || ((s.mode == MODE_VBLANK) && s.stat_en[1])
            || ((s.mode == MODE_OAM) && s.stat_en[2]);
        return lvl;
    endfunction

endpackage

// ----- rtl/core/lmt_if.sv -----
// Handshake interfaces for the command, response and configuration channels.
interface lmt_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [6:0] dot_count;
    logic [1:0] register_select;
    logic [7:0] write_data;

    modport source (output valid, output operation, output dot_count,
                    output register_select, output write_data, input ready);
    modport sink (input valid, input operation, input dot_count,
                  input register_select, input write_data, output ready);
endinterface

interface lmt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       render_start;
    logic       frame_end;
    logic [7:0] current_line;
    logic [1:0] current_mode;

    modport source (output valid, output read_data, output vblank_irq, output stat_irq,
                    output render_start, output frame_end, output current_line,
                    output current_mode, input ready);
    modport sink (input valid, input read_data, input vblank_irq, input stat_irq,
                  input render_start, input frame_end, input current_line,
                  input current_mode, output ready);
endinterface

interface lmt_cfg_if;
    logic valid;
    logic ready;
    logic render_enable;

    modport source (output valid, output render_enable, input ready);
    modport sink (input valid, input render_enable, output ready);
endinterface

// ----- rtl/core/lcd_mode_timing_stat_irq.sv -----
// Top level of the LCD mode timing block: command register, timing state and response register.
//
//   channel | role   | word
//   --------+--------+------------------------------------------------------------
//   cmd     | sink   | operation, dot_count, register_select, write_data
//   rsp     | source | read_data, irq and flag bits, current_line, current_mode
//   cfg     | sink   | render_enable, always ready
//
// A word is held in the command register and is then processed combinationally
// into the response register, so one word per cycle is sustained while rsp is ready.
// The command register takes a new word while the response register still waits.
// A stall on rsp holds both registers; cmd ready drops only when both are full.
// Reset clears the timing state, empties both registers and sets render_enable.
module lcd_mode_timing_stat_irq (
    input logic         clk,
    input logic         rst_n,
    lmt_cmd_if.sink     cmd,
    lmt_rsp_if.source   rsp,
    lmt_cfg_if.sink     cfg
);

    logic                   cmd_valid_reg;
    lmt_pkg::item_t         cmd_item_reg;
    logic                   rsp_valid_reg;
    lmt_pkg::result_t       rsp_res_reg;
    logic                   render_enable_reg;
    lmt_pkg::timing_state_t state_reg;
    lmt_pkg::timing_state_t state_next;
    lmt_pkg::result_t       res_next;
    logic                   step;

    assign step      = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || step;
    assign cfg.ready = 1'b1;

    lmt_step u_step (
        .st            (state_reg),
        .item          (cmd_item_reg),
        .render_enable (render_enable_reg),
        .st_next       (state_next),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg     <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            render_enable_reg <= 1'b1;
            state_reg         <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (step)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                render_enable_reg <= cfg.render_enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_item_reg.operation       <= cmd.operation;
            cmd_item_reg.dot_count       <= cmd.dot_count;
            cmd_item_reg.register_select <= cmd.register_select;
            cmd_item_reg.write_data      <= cmd.write_data;
        end
        if (step)
        begin
            rsp_res_reg <= res_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = rsp_res_reg.read_data;
    assign rsp.vblank_irq   = rsp_res_reg.vblank_irq;
    assign rsp.stat_irq     = rsp_res_reg.stat_irq;
    assign rsp.render_start = rsp_res_reg.render_start;
    assign rsp.frame_end    = rsp_res_reg.frame_end;
    assign rsp.current_line = rsp_res_reg.current_line;
    assign rsp.current_mode = rsp_res_reg.current_mode;

endmodule

// ----- rtl/core/lmt_step.sv -----
// Next-state and result logic for one command word of the LCD mode timing block.
module lmt_step (
    input  lmt_pkg::timing_state_t st,
    input  lmt_pkg::item_t         item,
    input  logic                   render_enable,
    output lmt_pkg::timing_state_t st_next,
    output lmt_pkg::result_t       res
);

    always_comb
    begin
        logic       on_now;
        logic       on_new;
        logic       eval;
        logic       lvl;
        logic [9:0] adv;
        logic [9:0] sum;
        logic [9:0] bound;
        logic [7:0] ly_inc;
        lmt_pkg::timing_state_t s;

        s      = st;
        res    = '0;
        eval   = 1'b0;
        on_now = st.control[lmt_pkg::CTRL_ON_BIT];

        adv = (item.dot_count > lmt_pkg::MAX_ADVANCE) ? {3'b000, lmt_pkg::MAX_ADVANCE}
                                                      : {3'b000, item.dot_count};
        sum = {1'b0, st.dot} + adv;

        // An advance of at most 80 dots crosses no more than one mode boundary.
        if (st.line >= lmt_pkg::VBLANK_LINE)
        begin
            bound = lmt_pkg::DOTS_PER_LINE;
        end
        else if ({1'b0, st.dot} < lmt_pkg::MODE3_START)
        begin
            bound = lmt_pkg::MODE3_START;
        end
        else if ({1'b0, st.dot} < lmt_pkg::MODE0_START)
        begin
            bound = lmt_pkg::MODE0_START;
        end
        else
        begin
            bound = lmt_pkg::DOTS_PER_LINE;
        end

        ly_inc = (st.line == lmt_pkg::LINES_PER_FRAME - 8'd1) ? 8'd0 : st.line + 8'd1;

        case (item.operation)
            lmt_pkg::OP_ADVANCE:
            begin
                if (on_now)
                begin
                    if (sum >= bound)
                    begin
                        eval = 1'b1;
                        if (bound == lmt_pkg::DOTS_PER_LINE)
                        begin
                            s.dot  = 9'(sum - lmt_pkg::DOTS_PER_LINE);
                            s.line = ly_inc;
                            if (ly_inc == lmt_pkg::VBLANK_LINE)
                            begin
                                s.mode         = lmt_pkg::MODE_VBLANK;
                                res.vblank_irq = 1'b1;
                                res.frame_end  = 1'b1;
                            end
                            else if (ly_inc < lmt_pkg::VBLANK_LINE)
                            begin
                                s.mode = lmt_pkg::MODE_OAM;
                            end
                        end
                        else if (bound == lmt_pkg::MODE3_START)
                        begin
                            s.dot            = sum[8:0];
                            s.mode           = lmt_pkg::MODE_DRAW;
                            res.render_start = render_enable;
                        end
                        else
                        begin
                            s.dot  = sum[8:0];
                            s.mode = lmt_pkg::MODE_HBLANK;
                        end
                    end
                    else
                    begin
                        s.dot = sum[8:0];
                    end
                end
                else
                begin
                    // With the display off the counters run freely without mode changes.
                    if (sum >= lmt_pkg::DOTS_PER_LINE)
                    begin
                        s.dot         = 9'(sum - lmt_pkg::DOTS_PER_LINE);
                        s.line        = ly_inc;
                        res.frame_end = (ly_inc == 8'd0);
                    end
                    else
                    begin
                        s.dot = sum[8:0];
                    end
                end
            end
            lmt_pkg::OP_WRITE:
            begin
                case (item.register_select)
                    lmt_pkg::REG_CONTROL:
                    begin
                        s.control = item.write_data;
                        if (on_now && !item.write_data[lmt_pkg::CTRL_ON_BIT])
                        begin
                            s.line  = 8'd0;
                            s.dot   = 9'd0;
                            s.mode  = lmt_pkg::MODE_HBLANK;
                            s.level = 1'b0;
                        end
                        else if (!on_now && item.write_data[lmt_pkg::CTRL_ON_BIT])
                        begin
                            s.line = 8'd0;
                            s.dot  = 9'd0;
                            s.mode = lmt_pkg::MODE_OAM;
                            eval   = 1'b1;
                        end
                    end
                    lmt_pkg::REG_STATUS:
                    begin
                        s.stat_en = item.write_data[6:3];
                        eval      = 1'b1;
                    end
                    lmt_pkg::REG_COMPARE:
                    begin
                        s.line_compare = item.write_data;
                        eval           = 1'b1;
                    end
                    default:
                    begin
                        // The line number register is read-only.
                    end
                endcase
            end
            lmt_pkg::OP_READ:
            begin
                case (item.register_select)
                    lmt_pkg::REG_CONTROL:
                    begin
                        res.read_data = st.control;
                    end
                    lmt_pkg::REG_STATUS:
                    begin
                        res.read_data = lmt_pkg::STATUS_FIXED
                                      | {1'b0, st.stat_en, 3'b000}
                                      | {5'b00000, (st.line == st.line_compare), 2'b00}
                                      | {6'b000000, (on_now ? st.mode : lmt_pkg::MODE_HBLANK)};
                    end
                    lmt_pkg::REG_LINE:
                    begin
                        res.read_data = st.line;
                    end
                    default:
                    begin
                        res.read_data = st.line_compare;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        on_new = s.control[lmt_pkg::CTRL_ON_BIT];
        lvl    = lmt_pkg::stat_level(s);
        if (eval)
        begin
            s.level      = on_new & lvl;
            res.stat_irq = on_new & lvl & ~st.level;
        end

        res.current_line = s.line;
        res.current_mode = on_new ? s.mode : lmt_pkg::MODE_HBLANK;
        st_next          = s;
    end

endmodule
